// ----- rtl/core/ppmhp_pkg.sv -----
// Shared types, constants and codes for the P6 header parser core.
`timescale 1ns / 1ps
`default_nettype none

package ppmhp_pkg;

    // Field and register widths
    localparam int unsigned DIM_W     = 27;
    localparam int unsigned ACC_W     = 31;
    localparam int unsigned CNT_W     = 55;
    localparam int unsigned MUL_SPLIT = 14;
    localparam int unsigned MUL_W     = DIM_W + MUL_SPLIT;

    localparam logic [DIM_W-1:0] MAX_DIM_RESET = 27'd100000000;
    localparam logic [ACC_W-1:0] MAXVAL_REQ    = 31'd255;

    // Result queue depth (entries)
    localparam int unsigned OFIFO_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef enum logic [3:0] {
        PH_P,
        PH_6,
        PH_SKIP_W,
        PH_DIG_W,
        PH_SKIP_H,
        PH_DIG_H,
        PH_SKIP_M,
        PH_DIG_M,
        PH_MUL_LO,
        PH_MUL_HI,
        PH_MUL_ADD,
        PH_MUL_TRIPLE,
        PH_PAYLOAD,
        PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MALFORMED,
        ST_DIMENSION,
        ST_SHORT
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } in_beat_t;

    typedef struct packed {
        logic             item_kind;
        logic [7:0]       pixel_byte;
        logic [1:0]       frame_status;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic             run_last;
    } out_beat_t;

    // Controller to datapath
    typedef struct packed {
        logic    acc_load;
        logic    acc_step;
        logic    hold_w;
        logic    hold_h;
        logic    comment_set;
        logic    comment_clr;
        logic    fail_set;
        status_t fail_code;
        logic    mul_lo;
        logic    mul_hi;
        logic    mul_add;
        logic    mul_triple;
        logic    seen_inc;
        logic    push_pixel;
        logic    push_final;
        status_t final_status;
        logic    clear_frame;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic    is_digit;
        logic    is_space;
        logic    is_hash;
        logic    is_newline;
        logic    is_p;
        logic    is_six;
        logic    in_comment;
        logic    acc_over;
        logic    acc_eq_maxval;
        logic    acc_step_eq_maxval;
        logic    dims_bad;
        logic    seen_lt_need;
        logic    seen_last;
        status_t err_code;
        logic    out_room;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppmhp_out_fifo.sv -----
// Small result queue: takes up to two beats per cycle, gives one while m_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module ppmhp_out_fifo (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [1:0]          wr_cnt,
    input  wire ppmhp_pkg::out_beat_t wr_item0,
    input  wire ppmhp_pkg::out_beat_t wr_item1,
    output logic                     room,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ppmhp_pkg::out_beat_t     m_payload
);

    localparam int unsigned DEPTH = ppmhp_pkg::OFIFO_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ppmhp_pkg::out_beat_t entry_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic             pop;

    assign pop          = m_valid && m_ready;
    assign m_valid      = (count_reg != '0);
    assign m_payload    = entry_mem[rd_ptr_reg];
    assign room         = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(wr_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (wr_cnt != 2'd0) begin
            entry_mem[wr_ptr_reg] <= wr_item0;
        end
        if (wr_cnt == 2'd2) begin
            entry_mem[wr_ptr_plus1] <= wr_item1;
        end
    end

    // Writes only land when there is space for them
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_cnt != 2'd0) |-> (count_reg + CNT_W'(wr_cnt) <= CNT_W'(DEPTH)))
        else $error("result queue overflow");

endmodule

`default_nettype wire

// ----- rtl/core/ppmhp_datapath.sv -----
// Parser datapath: byte classes, digit accumulator, dimensions, payload counters.
`timescale 1ns / 1ps
`default_nettype none

module ppmhp_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ppmhp_pkg::DIM_W-1:0]       cfg_wr_data,
    input  wire ppmhp_pkg::in_beat_t               s_payload,
    input  wire ppmhp_pkg::dp_cmd_t                cmd,
    input  wire logic                              out_room,
    output ppmhp_pkg::dp_stat_t                    stat,
    output logic [1:0]                             wr_cnt,
    output ppmhp_pkg::out_beat_t                   wr_item0,
    output ppmhp_pkg::out_beat_t                   wr_item1
);

    localparam int unsigned DIM_W = ppmhp_pkg::DIM_W;
    localparam int unsigned ACC_W = ppmhp_pkg::ACC_W;
    localparam int unsigned CNT_W = ppmhp_pkg::CNT_W;
    localparam int unsigned SPL   = ppmhp_pkg::MUL_SPLIT;
    localparam int unsigned MUL_W = ppmhp_pkg::MUL_W;

    logic [DIM_W-1:0]     max_dim_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [DIM_W-1:0]     held_w_reg;
    logic [DIM_W-1:0]     held_h_reg;
    logic [CNT_W-1:0]     need_reg;
    logic [CNT_W-1:0]     seen_reg;
    logic [MUL_W-1:0]     mul_reg;
    logic                 comment_reg;
    ppmhp_pkg::status_t   err_reg;

    logic [7:0]           b;
    logic [ACC_W-1:0]     digit_val;
    logic [ACC_W-1:0]     acc_mac;
    logic [DIM_W-1:0]     held_val;
    logic [SPL-1:0]       mul_op;
    logic [MUL_W-1:0]     mul_prod;
    logic [CNT_W-1:0]     seen_plus1;
    ppmhp_pkg::out_beat_t pixel_item;
    ppmhp_pkg::out_beat_t final_item;

    assign b         = s_payload.data_byte;
    assign digit_val = ACC_W'(b - ppmhp_pkg::CH_ZERO);
    assign acc_mac   = (acc_reg << 3) + (acc_reg << 1) + digit_val;
    assign held_val  = stat.acc_over ? '0 : acc_reg[DIM_W-1:0];
    assign seen_plus1 = seen_reg + CNT_W'(1);

    // Byte classes and flags for the controller
    always_comb begin
        stat.is_digit   = (b >= ppmhp_pkg::CH_ZERO) && (b <= ppmhp_pkg::CH_NINE);
        stat.is_space   = (b == ppmhp_pkg::CH_SPACE)
                       || ((b >= ppmhp_pkg::CH_TAB) && (b <= ppmhp_pkg::CH_CR));
        stat.is_hash    = (b == ppmhp_pkg::CH_HASH);
        stat.is_newline = (b == ppmhp_pkg::CH_LF);
        stat.is_p       = (b == ppmhp_pkg::CH_P);
        stat.is_six     = (b == ppmhp_pkg::CH_SIX);
        stat.in_comment = comment_reg;
        stat.acc_over   = (acc_reg > ACC_W'(max_dim_reg));
        stat.acc_eq_maxval      = (acc_reg == ppmhp_pkg::MAXVAL_REQ);
        stat.acc_step_eq_maxval = (acc_mac == ppmhp_pkg::MAXVAL_REQ);
        stat.dims_bad   = (held_w_reg == '0) || (held_h_reg == '0)
                       || (held_w_reg > max_dim_reg) || (held_h_reg > max_dim_reg);
        stat.seen_lt_need = (seen_reg < need_reg);
        stat.seen_last  = (seen_plus1 == need_reg);
        stat.err_code   = err_reg;
        stat.out_room   = out_room;
    end

    // Shared 27x14 multiplier: low then high half of the height
    assign mul_op   = cmd.mul_lo ? held_h_reg[SPL-1:0] : SPL'(held_h_reg[DIM_W-1:SPL]);
    assign mul_prod = MUL_W'(held_w_reg) * MUL_W'(mul_op);

    // Result beats
    always_comb begin
        pixel_item              = '0;
        pixel_item.item_kind    = ppmhp_pkg::KIND_PIXEL;
        pixel_item.pixel_byte   = b;

        final_item              = '0;
        final_item.item_kind    = ppmhp_pkg::KIND_FINAL;
        final_item.frame_status = cmd.final_status;
        final_item.run_last     = 1'b1;
        if (cmd.final_status == ppmhp_pkg::ST_OK) begin
            final_item.image_width  = held_w_reg;
            final_item.image_height = held_h_reg;
        end

        if (cmd.push_pixel) begin
            wr_item0 = pixel_item;
            wr_item1 = final_item;
            wr_cnt   = cmd.push_final ? 2'd2 : 2'd1;
        end else begin
            wr_item0 = final_item;
            wr_item1 = final_item;
            wr_cnt   = cmd.push_final ? 2'd1 : 2'd0;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dim_reg <= ppmhp_pkg::MAX_DIM_RESET;
        end else if (cfg_wr_en) begin
            max_dim_reg <= cfg_wr_data;
        end
    end

    // Frame state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_frame) begin
            acc_reg     <= '0;
            held_w_reg  <= '0;
            held_h_reg  <= '0;
            need_reg    <= '0;
            seen_reg    <= '0;
            comment_reg <= 1'b0;
            err_reg     <= ppmhp_pkg::ST_OK;
        end else begin
            if (cmd.acc_load) begin
                acc_reg <= digit_val;
            end else if (cmd.acc_step) begin
                acc_reg <= acc_mac;
            end
            if (cmd.hold_w) begin
                held_w_reg <= held_val;
            end
            if (cmd.hold_h) begin
                held_h_reg <= held_val;
            end
            if (cmd.comment_clr) begin
                comment_reg <= 1'b0;
            end else if (cmd.comment_set) begin
                comment_reg <= 1'b1;
            end
            if (cmd.fail_set) begin
                err_reg <= cmd.fail_code;
            end
            // need = 3 * w * h, built up in the mul_hi, mul_add and mul_triple steps
            if (cmd.mul_hi) begin
                need_reg <= CNT_W'(mul_reg);
            end else if (cmd.mul_add) begin
                need_reg <= need_reg + (CNT_W'(mul_reg) << SPL);
            end else if (cmd.mul_triple) begin
                need_reg <= need_reg + {need_reg[CNT_W-2:0], 1'b0};
            end
            if (cmd.mul_lo) begin
                seen_reg <= '0;
            end else if (cmd.seen_inc) begin
                seen_reg <= seen_plus1;
            end
        end
    end

    // Product register, no reset
    always_ff @(posedge aclk) begin
        if (cmd.mul_lo || cmd.mul_hi) begin
            mul_reg <= mul_prod;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ppmhp_ctrl.sv -----
// Parser controller: header phase machine, multiply sequencing, result requests.
`timescale 1ns / 1ps
`default_nettype none

module ppmhp_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                end_of_data,
    output logic                     s_ready,
    input  wire ppmhp_pkg::dp_stat_t stat,
    output ppmhp_pkg::dp_cmd_t       cmd
);

    ppmhp_pkg::phase_t  state_reg, state_next;
    ppmhp_pkg::phase_t  ph;
    ppmhp_pkg::phase_t  skip_dig;
    ppmhp_pkg::status_t fail_code;
    logic               accept;
    logic               busy_mul;
    logic               do_skip;
    logic               do_acc;
    logic               finish;
    logic               finish_now;
    logic               maxval_ok;
    logic               fail;
    logic               short_end;

    assign busy_mul = (state_reg == ppmhp_pkg::PH_MUL_LO)
                   || (state_reg == ppmhp_pkg::PH_MUL_HI)
                   || (state_reg == ppmhp_pkg::PH_MUL_ADD)
                   || (state_reg == ppmhp_pkg::PH_MUL_TRIPLE);
    assign s_ready  = !busy_mul && stat.out_room;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppmhp_pkg::PH_P;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next phase and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        ph         = state_reg;
        skip_dig   = ppmhp_pkg::PH_DIG_W;
        fail_code  = ppmhp_pkg::ST_MALFORMED;
        do_skip    = 1'b0;
        do_acc     = 1'b0;
        finish     = 1'b0;
        finish_now = 1'b0;
        maxval_ok  = 1'b0;
        fail       = 1'b0;
        short_end  = 1'b0;

        unique case (state_reg)
            ppmhp_pkg::PH_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ppmhp_pkg::PH_MUL_HI;
            end
            ppmhp_pkg::PH_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ppmhp_pkg::PH_MUL_ADD;
            end
            ppmhp_pkg::PH_MUL_ADD: begin
                cmd.mul_add = 1'b1;
                state_next  = ppmhp_pkg::PH_MUL_TRIPLE;
            end
            ppmhp_pkg::PH_MUL_TRIPLE: begin
                cmd.mul_triple = 1'b1;
                state_next     = ppmhp_pkg::PH_PAYLOAD;
            end
            default: begin
            end
        endcase

        if (accept) begin
            // Per-phase handling of the byte
            unique case (state_reg)
                ppmhp_pkg::PH_P: begin
                    if (stat.is_p) ph = ppmhp_pkg::PH_6;
                    else           fail = 1'b1;
                end
                ppmhp_pkg::PH_6: begin
                    if (stat.is_six) ph = ppmhp_pkg::PH_SKIP_W;
                    else             fail = 1'b1;
                end
                ppmhp_pkg::PH_SKIP_W: begin
                    do_skip  = 1'b1;
                    skip_dig = ppmhp_pkg::PH_DIG_W;
                end
                ppmhp_pkg::PH_SKIP_H: begin
                    do_skip  = 1'b1;
                    skip_dig = ppmhp_pkg::PH_DIG_H;
                end
                ppmhp_pkg::PH_SKIP_M: begin
                    do_skip  = 1'b1;
                    skip_dig = ppmhp_pkg::PH_DIG_M;
                end
                ppmhp_pkg::PH_DIG_W: begin
                    if (stat.is_digit) begin
                        do_acc = 1'b1;
                    end else begin
                        cmd.hold_w = 1'b1;
                        ph         = ppmhp_pkg::PH_SKIP_H;
                        do_skip    = 1'b1;
                        skip_dig   = ppmhp_pkg::PH_DIG_H;
                    end
                end
                ppmhp_pkg::PH_DIG_H: begin
                    if (stat.is_digit) begin
                        do_acc = 1'b1;
                    end else begin
                        cmd.hold_h = 1'b1;
                        ph         = ppmhp_pkg::PH_SKIP_M;
                        do_skip    = 1'b1;
                        skip_dig   = ppmhp_pkg::PH_DIG_M;
                    end
                end
                ppmhp_pkg::PH_DIG_M: begin
                    if (stat.is_digit) do_acc = 1'b1;
                    else               finish = 1'b1;
                end
                ppmhp_pkg::PH_PAYLOAD: begin
                    if (stat.seen_lt_need) begin
                        cmd.push_pixel = 1'b1;
                        cmd.seen_inc   = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // Whitespace, comments, or first digit of the next number
            if (do_skip) begin
                priority if (stat.in_comment) begin
                    cmd.comment_clr = stat.is_newline;
                end else if (stat.is_space) begin
                end else if (stat.is_hash) begin
                    cmd.comment_set = 1'b1;
                end else if (stat.is_digit) begin
                    cmd.acc_load = 1'b1;
                    ph           = skip_dig;
                end else begin
                    fail = 1'b1;
                end
            end

            // Further digit, rejected once the accumulator is over the cap
            if (do_acc) begin
                if (stat.acc_over) fail = 1'b1;
                else               cmd.acc_step = 1'b1;
            end

            // Maxval check, also when the stream ends in the maxval digits
            finish_now = finish || (end_of_data && (state_reg == ppmhp_pkg::PH_DIG_M) && !fail);
            maxval_ok  = finish ? stat.acc_eq_maxval : stat.acc_step_eq_maxval;
            if (finish_now) begin
                priority if (!maxval_ok) begin
                    fail = 1'b1;
                end else if (stat.dims_bad) begin
                    fail      = 1'b1;
                    fail_code = ppmhp_pkg::ST_DIMENSION;
                end else if (end_of_data) begin
                    short_end = 1'b1;
                end else begin
                    ph = ppmhp_pkg::PH_MUL_LO;
                end
            end

            if (fail) begin
                cmd.fail_set    = 1'b1;
                cmd.fail_code   = fail_code;
                cmd.comment_clr = 1'b1;
                ph              = ppmhp_pkg::PH_FAIL;
            end

            // Last byte: final status beat and back to the magic
            if (end_of_data) begin
                cmd.push_final  = 1'b1;
                cmd.clear_frame = 1'b1;
                state_next      = ppmhp_pkg::PH_P;
                priority if (fail) begin
                    cmd.final_status = fail_code;
                end else if (short_end) begin
                    cmd.final_status = ppmhp_pkg::ST_SHORT;
                end else if (ph == ppmhp_pkg::PH_FAIL) begin
                    cmd.final_status = stat.err_code;
                end else if (ph == ppmhp_pkg::PH_PAYLOAD) begin
                    cmd.final_status = (!stat.seen_lt_need || stat.seen_last)
                                     ? ppmhp_pkg::ST_OK : ppmhp_pkg::ST_SHORT;
                end else begin
                    cmd.final_status = ppmhp_pkg::ST_MALFORMED;
                end
            end else begin
                state_next = ph;
            end
        end
    end

    // No byte is taken while the pixel count is being formed
    a_mul_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_mul |-> !s_ready)
        else $error("byte accepted during size multiply");

    // The multiply sequence always lands in the payload phase
    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ppmhp_pkg::PH_MUL_TRIPLE) |=> (state_reg == ppmhp_pkg::PH_PAYLOAD))
        else $error("multiply sequence did not end in payload");

    // A last byte restarts the parse at the magic
    a_eod_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && end_of_data) |=> (state_reg == ppmhp_pkg::PH_P))
        else $error("parser did not restart after last byte");

    // A pixel beat only comes from the payload phase
    a_pixel_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push_pixel |-> (accept && (state_reg == ppmhp_pkg::PH_PAYLOAD)))
        else $error("pixel beat outside payload");

endmodule

`default_nettype wire

// ----- rtl/core/ppm_p6_header_parser_core.sv -----
// Top level of the binary PPM (P6) header parser and pixel forwarder.
//
//  channel   direction  handshake            beat contents
//  s_        in         s_valid / s_ready    in_beat_t: data_byte, end_of_data
//  m_        out        m_valid / m_ready    out_beat_t: pixel or final status
//  cfg_      in         cfg_wr_en            max_dimension (27 bits)
//
// Input bytes can come back to back. After the byte that ends maxval, s_ready
// is low in MUL_LO, MUL_HI, MUL_ADD and MUL_TRIPLE, which form 3*w*h on a
// shared 27x14 multiplier (two partial products, one add, one triple).
// Results go through a 4-beat queue; s_ready drops while fewer than two
// entries are free, so a stalled m_ side holds the input once three results
// wait (four when a pixel and a frame end land in the same cycle).
// aresetn is synchronous and active low; it restores max_dimension to 1e8.
`timescale 1ns / 1ps
`default_nettype none

module ppm_p6_header_parser_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ppmhp_pkg::DIM_W-1:0] cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire ppmhp_pkg::in_beat_t         s_payload,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output ppmhp_pkg::out_beat_t             m_payload
);

    ppmhp_pkg::dp_cmd_t   cmd;
    ppmhp_pkg::dp_stat_t  stat;
    ppmhp_pkg::out_beat_t wr_item0;
    ppmhp_pkg::out_beat_t wr_item1;
    logic [1:0]           wr_cnt;
    logic                 out_room;

    ppmhp_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .end_of_data (s_payload.end_of_data),
        .s_ready     (s_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    ppmhp_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_payload   (s_payload),
        .cmd         (cmd),
        .out_room    (out_room),
        .stat        (stat),
        .wr_cnt      (wr_cnt),
        .wr_item0    (wr_item0),
        .wr_item1    (wr_item1)
    );

    ppmhp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_cnt    (wr_cnt),
        .wr_item0  (wr_item0),
        .wr_item1  (wr_item1),
        .room      (out_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the P6 header parser core: directed table, then random frames.
`timescale 1ns / 1ps

module tb;
    import ppmhp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASE_BEATS = 115;
    localparam int unsigned NUM_PHASES  = 7;
    localparam int unsigned SETTLE      = 16;

    // One row of the directed table; a typed row carries the frame end to expect
    typedef struct packed {
        logic [7:0]       data;
        logic             eod;
        logic             typed;
        status_t          st;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } vector_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [DIM_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    in_beat_t         s_payload   = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    out_beat_t        m_payload;

    // Predictor state
    longint unsigned dim_cap;
    phase_t          hdr_phase;
    bit              skipping_comment;
    longint unsigned digits_val;
    longint unsigned frame_w;
    longint unsigned frame_h;
    longint unsigned bytes_needed;
    longint unsigned bytes_forwarded;
    status_t         frame_err;

    out_beat_t       frame_results_q[$];
    out_beat_t       oldest_result;
    logic [7:0]      file_bytes[$];

    bit              no_idle;
    int unsigned     errors;
    int unsigned     beats_sent;
    int unsigned     pixels_seen;
    int unsigned     frames_seen;
    int unsigned     cap_writes;
    int unsigned     cycle_count;

    // Directed table: ok 1x1 frame (no separator, comment, pixel and end together),
    // bad maxval with zero width, zero height, bad byte before a number.
    vector_t directed_vecs[36] = '{
        '{CH_P,     1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_SIX,   1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"1",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_HASH,  1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_LF,    1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"1",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_SPACE, 1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"2",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"5",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"5",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_TAB,   1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{8'h00,    1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{8'hFF,    1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{8'h80,    1'b1, 1'b1, ST_OK,        27'd1, 27'd1},
        '{CH_P,     1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_SIX,   1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"0",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_SPACE, 1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"1",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_SPACE, 1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"2",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"5",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"4",      1'b1, 1'b1, ST_MALFORMED, 27'd0, 27'd0},
        '{CH_P,     1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_SIX,   1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"1",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_SPACE, 1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"0",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_SPACE, 1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"2",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"5",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"5",      1'b1, 1'b1, ST_DIMENSION, 27'd0, 27'd0},
        '{CH_P,     1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{CH_SIX,   1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"x",      1'b0, 1'b0, ST_OK,        27'd0, 27'd0},
        '{"5",      1'b1, 1'b1, ST_MALFORMED, 27'd0, 27'd0}
    };

    ppm_p6_header_parser_core i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    function automatic bit is_digit_byte(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_blank(logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic void clear_frame_state();
        hdr_phase        = PH_P;
        skipping_comment = 1'b0;
        digits_val       = 0;
        frame_w          = 0;
        frame_h          = 0;
        bytes_needed     = 0;
        bytes_forwarded  = 0;
        frame_err        = ST_OK;
    endfunction

    function automatic void reject(status_t code);
        frame_err        = code;
        hdr_phase        = PH_FAIL;
        skipping_comment = 1'b0;
    endfunction

    function automatic void push_pixel(logic [7:0] d);
        out_beat_t r;
        r            = '0;
        r.item_kind  = KIND_PIXEL;
        r.pixel_byte = d;
        frame_results_q.push_back(r);
    endfunction

    function automatic void push_frame_end(status_t st);
        out_beat_t r;
        r              = '0;
        r.item_kind    = KIND_FINAL;
        r.frame_status = st;
        r.run_last     = 1'b1;
        if (st == ST_OK) begin
            r.image_width  = frame_w[DIM_W-1:0];
            r.image_height = frame_h[DIM_W-1:0];
        end
        frame_results_q.push_back(r);
    endfunction

    // Whitespace and comments before a number, or its first digit
    function automatic void skip_or_start(logic [7:0] b);
        if (skipping_comment) begin
            if (b == CH_LF)
                skipping_comment = 1'b0;
        end else if (b == CH_HASH) begin
            skipping_comment = 1'b1;
        end else if (is_digit_byte(b)) begin
            digits_val = b - CH_ZERO;
            // each digit phase follows its skip phase
            hdr_phase  = phase_t'(hdr_phase + 1);
        end else if (!is_blank(b)) begin
            reject(ST_MALFORMED);
        end
    endfunction

    function automatic void add_digit(logic [7:0] b);
        if (digits_val > dim_cap)
            reject(ST_MALFORMED);
        else
            digits_val = digits_val * 10 + (b - CH_ZERO);
    endfunction

    // a dimension over the cap is held as 0 so that the range check catches it
    function automatic longint unsigned capped_val();
        return (digits_val > dim_cap) ? 0 : digits_val;
    endfunction

    function automatic void close_maxval();
        if (digits_val != 255) begin
            reject(ST_MALFORMED);
        end else if (frame_w == 0 || frame_h == 0 || frame_w > dim_cap || frame_h > dim_cap) begin
            reject(ST_DIMENSION);
        end else begin
            bytes_needed    = 3 * frame_w * frame_h;
            bytes_forwarded = 0;
            hdr_phase       = PH_PAYLOAD;
        end
    endfunction

    // Advance the frame by one byte and queue the beats it produces
    function automatic void parse_ppm_byte(logic [7:0] b, logic eod);
        status_t st;
        case (hdr_phase)
            PH_P: begin
                if (b == CH_P) hdr_phase = PH_6; else reject(ST_MALFORMED);
            end
            PH_6: begin
                if (b == CH_SIX) hdr_phase = PH_SKIP_W; else reject(ST_MALFORMED);
            end
            PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: skip_or_start(b);
            PH_DIG_W: begin
                if (is_digit_byte(b)) begin
                    add_digit(b);
                end else begin
                    frame_w   = capped_val();
                    hdr_phase = PH_SKIP_H;
                    skip_or_start(b);
                end
            end
            PH_DIG_H: begin
                if (is_digit_byte(b)) begin
                    add_digit(b);
                end else begin
                    frame_h   = capped_val();
                    hdr_phase = PH_SKIP_M;
                    skip_or_start(b);
                end
            end
            PH_DIG_M: begin
                if (is_digit_byte(b)) add_digit(b); else close_maxval();
            end
            PH_PAYLOAD: begin
                // bytes past the pixel count are dropped
                if (bytes_forwarded < bytes_needed) begin
                    push_pixel(b);
                    bytes_forwarded++;
                end
            end
            default: ;
        endcase

        if (eod) begin
            if (hdr_phase == PH_DIG_M)
                close_maxval();
            if (hdr_phase == PH_FAIL)
                st = frame_err;
            else if (hdr_phase == PH_PAYLOAD)
                st = (bytes_forwarded >= bytes_needed) ? ST_OK : ST_SHORT;
            else
                st = ST_MALFORMED;
            push_frame_end(st);
            clear_frame_state();
        end
    endfunction

    // ---------------------------------------------------------------- frame builder

    function automatic void add_number(longint unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 9) == 0)
            file_bytes.push_back(CH_ZERO);
        foreach (s[i])
            file_bytes.push_back(s[i]);
    endfunction

    // Separator run: blanks and comments, now and then a stray letter
    function automatic void add_gap(bit may_skip);
        int unsigned n;
        int unsigned k;
        logic [7:0]  c;
        n = may_skip ? $urandom_range(0, 2) : $urandom_range(1, 2);
        repeat (n) begin
            k = $urandom_range(0, 24);
            if (k == 0) begin
                file_bytes.push_back(8'(8'h41 + $urandom_range(0, 25)));
            end else if (k < 5) begin
                file_bytes.push_back(CH_HASH);
                repeat ($urandom_range(0, 4)) begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CH_LF) c = CH_SPACE;
                    file_bytes.push_back(c);
                end
                file_bytes.push_back(CH_LF);
            end else begin
                k = $urandom_range(0, 5);
                file_bytes.push_back(k == 5 ? CH_SPACE : 8'(CH_TAB + k));
            end
        end
    endfunction

    function automatic longint unsigned pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, dim_cap < 4 ? int'(dim_cap) : 4);
        if (r < 78) return 0;
        if (r < 86) return dim_cap;
        if (r < 93) return dim_cap + 1;
        // long enough for a digit to land on an accumulator past the cap
        return dim_cap * 100 + $urandom_range(0, 99);
    endfunction

    function automatic void build_frame();
        int unsigned     mode;
        longint unsigned w;
        longint unsigned h;
        longint unsigned mv;
        longint unsigned need;
        int unsigned     count;
        int unsigned     keep;
        logic [7:0]      c;
        file_bytes.delete();
        mode = $urandom_range(0, 99);
        if (mode >= 88) begin
            // noise, half of it behind a good magic
            if ($urandom_range(0, 1)) begin
                file_bytes.push_back(CH_P);
                file_bytes.push_back(CH_SIX);
            end
            repeat ($urandom_range(1, 6))
                file_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        file_bytes.push_back(CH_P);
        file_bytes.push_back(CH_SIX);
        add_gap(1'b1);
        w = pick_dim();
        add_number(w);
        add_gap(1'b0);
        h = pick_dim();
        add_number(h);
        add_gap(1'b0);
        mv = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 999) : 255;
        add_number(mv);
        // stream ends on the last maxval digit
        if (mode >= 80)
            return;
        c = 8'($urandom_range(0, 255));
        if (is_digit_byte(c)) c = c ^ 8'h40;
        file_bytes.push_back(c);
        if (mv == 255 && w >= 1 && h >= 1 && w <= dim_cap && h <= dim_cap)
            need = 3 * w * h;
        else
            need = 0;
        if (need == 0 || need > 48) begin
            count = $urandom_range(0, 4);
        end else begin
            keep = $urandom_range(0, 99);
            if (keep < 60) count = 32'(need);
            else if (keep < 75) count = 32'(need - 1);
            else count = 32'(need) + $urandom_range(1, 3);
        end
        repeat (count)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        // truncated file
        if (mode >= 70) begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep)
                void'(file_bytes.pop_back());
        end
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_byte(logic [7:0] d, logic eod, logic typed, status_t st,
                             logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        out_beat_t fixed;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{data_byte: d, end_of_data: eod};
        do @(posedge aclk); while (!s_ready);
        parse_ppm_byte(d, eod);
        beats_sent++;
        // typed rows replace the predicted frame end
        if (typed) begin
            fixed              = '0;
            fixed.item_kind    = KIND_FINAL;
            fixed.frame_status = st;
            fixed.image_width  = w;
            fixed.image_height = h;
            fixed.run_last     = 1'b1;
            frame_results_q[frame_results_q.size() - 1] = fixed;
        end
    endtask

    // Register write once the block has gone quiet
    task automatic set_max_dim(longint unsigned v);
        s_valid <= 1'b0;
        while (frame_results_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v[DIM_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        dim_cap = v;
        cap_writes++;
    endtask

    // Result side stalls in bursts
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, got %p", $time, m_payload);
            end else begin
                oldest_result = frame_results_q.pop_front();
                check_field("item_kind", oldest_result.item_kind, m_payload.item_kind);
                check_field("pixel_byte", oldest_result.pixel_byte, m_payload.pixel_byte);
                check_field("frame_status", oldest_result.frame_status, m_payload.frame_status);
                check_field("image_width", oldest_result.image_width, m_payload.image_width);
                check_field("image_height", oldest_result.image_height, m_payload.image_height);
                check_field("run_last", oldest_result.run_last, m_payload.run_last);
            end
            if (m_payload.item_kind == KIND_FINAL) frames_seen++; else pixels_seen++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** ppm_p6_header_parser_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        int unsigned phase_start;
        int unsigned waited;
        errors      = 0;
        beats_sent  = 0;
        pixels_seen = 0;
        frames_seen = 0;
        cap_writes  = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        dim_cap     = MAX_DIM_RESET;
        clear_frame_state();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at the reset value of max_dimension
        foreach (directed_vecs[i])
            send_byte(directed_vecs[i].data, directed_vecs[i].eod, directed_vecs[i].typed,
                      directed_vecs[i].st, directed_vecs[i].w, directed_vecs[i].h);

        // random frames under several caps; the last phase runs without idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1: set_max_dim(1);
                2: set_max_dim(12);
                3: set_max_dim(MAX_DIM_RESET);
                4: set_max_dim($urandom_range(5, 999));
                5: set_max_dim(1);
                6: set_max_dim(3);
                default: ;
            endcase
            no_idle     = (p == NUM_PHASES - 1);
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                build_frame();
                foreach (file_bytes[i])
                    send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, ST_OK, '0, '0);
            end
        end

        // drain, then a short quiet window for stray beats
        s_valid <= 1'b0;
        waited = 0;
        while (frame_results_q.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (frame_results_q.size() != 0) begin
            errors++;
            $display("%0t: %0d beats never arrived, next expected %p", $time,
                     frame_results_q.size(), frame_results_q[0]);
        end

        $display("Sent %0d bytes; checked %0d pixel beats and %0d frame ends.",
                 beats_sent, pixels_seen, frames_seen);
        $display("max_dimension written %0d times, ranging from 1 to 100000000.", cap_writes);
        if (errors == 0)
            $display("** ppm_p6_header_parser_core: PASSED **");
        else
            $display("** ppm_p6_header_parser_core: FAILED **");
        $finish;
    end

endmodule
